// File: src/bocs_pkg.sv
package bocs_pkg;

  localparam int unsigned CTX_SAMPLES       = 1024;
  localparam int unsigned MAX_BLOCK_SAMPLES = 16384;

  localparam int unsigned SMP_W  = 24;
  localparam int unsigned LEN_W  = 15;
  localparam int unsigned IDX_W  = (CTX_SAMPLES > 1) ? $clog2(CTX_SAMPLES) : 1;
  localparam int unsigned FADE_W = $clog2(CTX_SAMPLES + 1);
  localparam int unsigned POS_W  = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;
  localparam int unsigned WS_W   = 17;
  localparam int unsigned W_W    = 16;
  localparam int unsigned PROD_W = W_W + SMP_W + 2;

  localparam logic [WS_W-1:0]   ONE_Q16 = WS_W'(65536);
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_READ,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic rd_en;
    logic mul_en;
    logic fin_en;
  } cmd_t;

  typedef struct packed {
    logic new_block;
    logic div_done;
  } status_t;

endpackage

// File: src/bocs_div.sv
module bocs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bocs_pkg::FADE_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [bocs_pkg::WS_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(bocs_pkg::WS_W + 1);

  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [bocs_pkg::WS_W-1:0]      dvd_q, dvd_d;
  logic [bocs_pkg::WS_W-1:0]      quo_q, quo_d;
  logic [bocs_pkg::FADE_W-1:0]    rem_q, rem_d;
  logic [bocs_pkg::FADE_W-1:0]    dsr_q, dsr_d;
  logic [bocs_pkg::FADE_W:0]      rem_sh;
  logic                           fits;

  // one quotient bit per cycle, restoring form
  assign rem_sh = {rem_q, dvd_q[bocs_pkg::WS_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d = CNT_W'(bocs_pkg::WS_W);
      dvd_d = bocs_pkg::ONE_Q16;
      quo_d = '0;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      dvd_d = {dvd_q[bocs_pkg::WS_W-2:0], 1'b0};
      quo_d = {quo_q[bocs_pkg::WS_W-2:0], fits};
      rem_d = fits ? bocs_pkg::FADE_W'(rem_sh - {1'b0, dsr_q})
                   : bocs_pkg::FADE_W'(rem_sh);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/bocs_ctrl.sv
module bocs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bocs_pkg::status_t  status_i,
  output bocs_pkg::cmd_t     cmd_o
);

  bocs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bocs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.new_block ? bocs_pkg::ST_DIV_GO : bocs_pkg::ST_READ;
        end
      end
      bocs_pkg::ST_DIV_GO:   state_d = bocs_pkg::ST_DIV_WAIT;
      bocs_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = bocs_pkg::ST_READ;
        end
      end
      bocs_pkg::ST_READ: state_d = bocs_pkg::ST_MUL;
      bocs_pkg::ST_MUL:  state_d = bocs_pkg::ST_FIN;
      bocs_pkg::ST_FIN:  state_d = bocs_pkg::ST_OUT;
      bocs_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = bocs_pkg::ST_IDLE;
        end
      end
      default: state_d = bocs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      bocs_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bocs_pkg::ST_DIV_GO:   cmd_o.div_start = 1'b1;
      bocs_pkg::ST_DIV_WAIT: ;
      bocs_pkg::ST_READ:     cmd_o.rd_en  = 1'b1;
      bocs_pkg::ST_MUL:      cmd_o.mul_en = 1'b1;
      bocs_pkg::ST_FIN:      cmd_o.fin_en = 1'b1;
      bocs_pkg::ST_OUT:      out_valid_o  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bocs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/bocs_dp.sv
module bocs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [bocs_pkg::SMP_W-1:0]   sample_i,
  input  logic        [bocs_pkg::LEN_W-1:0]   block_len_i,
  input  logic                                restart_i,
  input  bocs_pkg::cmd_t                      cmd_i,
  output bocs_pkg::status_t                   status_o,
  output logic signed [bocs_pkg::SMP_W-1:0]   spliced_sample_o,
  output logic                                block_end_o
);

  localparam int unsigned SMP_W  = bocs_pkg::SMP_W;
  localparam int unsigned LEN_W  = bocs_pkg::LEN_W;
  localparam int unsigned IDX_W  = bocs_pkg::IDX_W;
  localparam int unsigned FADE_W = bocs_pkg::FADE_W;
  localparam int unsigned POS_W  = bocs_pkg::POS_W;
  localparam int unsigned WS_W   = bocs_pkg::WS_W;
  localparam int unsigned W_W    = bocs_pkg::W_W;
  localparam int unsigned PROD_W = bocs_pkg::PROD_W;
  localparam int unsigned ADJ_W  = PROD_W - 16;

  // control state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              seen_q, seen_d;
  logic [FADE_W:0]   fill_q, fill_d;

  // payload
  logic signed [SMP_W-1:0]  smp_q;
  logic [WS_W-1:0]          ws_q;
  logic [W_W-1:0]           w_q;
  logic                     rdv_q, hit_q, save_q;
  logic [IDX_W-1:0]         widx_q;
  logic signed [SMP_W-1:0]  rd_q;
  logic signed [SMP_W-1:0]  prev_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SMP_W-1:0]  res_q;
  logic                     end_q;

  logic signed [SMP_W-1:0]  mem [bocs_pkg::CTX_SAMPLES];

  logic [POS_W-1:0]         pos_eff;
  logic [LEN_W-1:0]         len_clamp;
  logic [FADE_W-1:0]        fade;
  logic [LEN_W-1:0]         save_base;
  logic [LEN_W-1:0]         pos_ext;
  logic [IDX_W-1:0]         rd_idx;
  logic                     div_done;
  logic [WS_W-1:0]          div_quo;
  logic signed [SMP_W-1:0]  prev;
  logic signed [SMP_W:0]    diff;
  logic signed [W_W:0]      w_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ADJ_W-1:0]  adj;
  logic signed [ADJ_W-1:0]  sum;
  logic                     last;

  assign pos_eff = restart_i ? '0 : pos_q;
  assign status_o.new_block = (pos_eff == '0);
  assign status_o.div_done  = div_done;

  always_comb begin
    len_clamp = block_len_i;
    if (block_len_i == '0) begin
      len_clamp = LEN_W'(1);
    end else if ({1'b0, block_len_i} > (LEN_W + 1)'(bocs_pkg::MAX_BLOCK_SAMPLES)) begin
      len_clamp = LEN_W'(bocs_pkg::MAX_BLOCK_SAMPLES);
    end
  end

  assign fade = ({1'b0, len_q} < (LEN_W + 1)'(bocs_pkg::CTX_SAMPLES))
              ? FADE_W'(len_q) : FADE_W'(bocs_pkg::CTX_SAMPLES);
  assign save_base = len_q - LEN_W'(fade);
  assign pos_ext   = LEN_W'(pos_q);
  assign rd_idx    = IDX_W'(pos_q);

  bocs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (fade),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  // entries above the fill mark were never written since reset and read as zero
  assign prev   = rdv_q ? rd_q : '0;
  assign diff   = (SMP_W + 1)'(smp_q) - (SMP_W + 1)'(prev);
  assign w_s    = $signed({1'b0, w_q});
  assign prod_d = w_s * diff;

  assign rnd  = prod_q + $signed(bocs_pkg::HALF_LSB);
  assign adj  = rnd[PROD_W-1:16];
  assign sum  = ADJ_W'(prev_q) + adj;
  assign last = ((pos_ext + LEN_W'(1)) >= len_q);

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    seen_d = seen_q;
    fill_d = fill_q;
    if (cmd_i.accept) begin
      pos_d = pos_eff;
      if (restart_i) begin
        seen_d = 1'b0;
      end
      if (pos_eff == '0) begin
        len_d = len_clamp;
      end
    end
    if (cmd_i.mul_en && save_q && ((FADE_W + 1)'(widx_q) == fill_q)) begin
      fill_d = fill_q + (FADE_W + 1)'(1);
    end
    if (cmd_i.fin_en) begin
      if (last) begin
        pos_d  = '0;
        seen_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      seen_q <= 1'b0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      seen_q <= seen_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
    end
    if (div_done) begin
      ws_q <= div_quo;
    end
    if (cmd_i.rd_en) begin
      w_q    <= W_W'(rd_idx * ws_q);
      rdv_q  <= ((FADE_W + 1)'(rd_idx) < fill_q);
      hit_q  <= seen_q && (pos_ext < LEN_W'(fade));
      save_q <= (pos_ext >= save_base);
      widx_q <= IDX_W'(pos_ext - save_base);
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      prev_q <= prev;
    end
    if (cmd_i.fin_en) begin
      res_q <= hit_q ? SMP_W'(sum) : smp_q;
      end_q <= last;
    end
  end

  // tail store: read in the read step, written in the multiply step that follows
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_idx];
    end
    if (cmd_i.mul_en && save_q) begin
      mem[widx_q] <= smp_q;
    end
  end

  assign spliced_sample_o = res_q;
  assign block_end_o      = end_q;

endmodule

// File: src/block_overlap_crossfade_splicer_unit.sv
// sequence: accept a sample, read the tail store, multiply and write the tail, round, output;
//   the first sample of a block runs the 17-step weight divider before the read;
//   the next sample is taken once the result is taken
// reset: asynchronous active low, clears position, length, block flag and the tail fill mark;
//   tail entries above the fill mark read as zero, so no clearing pass is needed
module block_overlap_crossfade_splicer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transaction
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bocs_pkg::SMP_W-1:0]   sample_i,
  input  logic        [bocs_pkg::LEN_W-1:0]   block_len_i,
  input  logic                                restart_i,
  // output transaction
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bocs_pkg::SMP_W-1:0]   spliced_sample_o,
  output logic                                block_end_o
);

  // command and status between sequencer and datapath
  bocs_pkg::cmd_t    cmd;
  bocs_pkg::status_t status;

  // sequencer: accept, optional weight divide, tail read, multiply and
  // tail write, round and output, then hold until the transaction is taken
  bocs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: block position tracking, tail store, weight divider,
  // crossfade multiply and rounding, output registers
  bocs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_i),
    .block_len_i      (block_len_i),
    .restart_i        (restart_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .spliced_sample_o (spliced_sample_o),
    .block_end_o      (block_end_o)
  );

endmodule
